FILE: rtl/core/aimd_pkg.sv
// aimd_pkg: shared types and constants of the aimd congestion window engine
// no dependencies; used by the channel interfaces, the top level and the checker
package aimd_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned ACK_W = 16;
  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam logic [WIDTH-1:0] MIN_THRESHOLD = WIDTH'(2);
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_ACK   = 2'd1,
    OP_LOSS  = 2'd2,
    OP_UNDO  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DECIDE,
    ST_DIV,
    ST_GROW,
    ST_CLAMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e              opcode;
    logic [ACK_W-1:0] acked_count;
    logic [WIDTH-1:0] window_now;
    logic [WIDTH-1:0] threshold_now;
    logic [WIDTH-1:0] prior_window;
    logic             window_limited;
  } req_t;

  typedef struct packed {
    logic [WIDTH-1:0] window_out;
    logic [WIDTH-1:0] threshold_out;
    logic [WIDTH-1:0] loss_total;
  } rsp_t;

endpackage

FILE: rtl/core/aimd_req_if.sv
// aimd_req_if: valid/ready channel carrying one event request
// depends on aimd_pkg
interface aimd_req_if;
  import aimd_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/aimd_rsp_if.sv
// aimd_rsp_if: valid/ready channel carrying one window update result
// depends on aimd_pkg
interface aimd_rsp_if;
  import aimd_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/aimd_congestion_window_top.sv
// channel   dir  handshake         payload
// req_i     in   valid/ready       aimd_pkg::req_t event request
// rsp_o     out  valid/ready       aimd_pkg::rsp_t window, threshold, loss count
// cfg       in   cfg_we_i          cfg_wdata_i window clamp
//
// reset, loss, undo, ignored acks and avoidance acks without a full window:
// states SUM, DECIDE, DONE; slow start acks pass through CLAMP before DONE
// congestion avoidance growth adds DIV, GROW and CLAMP; DIV runs the bit-serial restoring
// divider (one quotient bit per cycle)
// one request in flight; the next is taken while a result waits in rsp_o
// rst_ni clears the clamp, the ack accumulator and the loss counter
//
// aimd_congestion_window_top: aimd congestion window engine
// depends on aimd_pkg, aimd_req_if, aimd_rsp_if
module aimd_congestion_window_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [aimd_pkg::WIDTH-1:0] cfg_wdata_i,
  aimd_req_if.sink                  req_i,
  aimd_rsp_if.source                rsp_o
);
  import aimd_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  logic [WIDTH-1:0] clamp_q;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] loss_q, loss_d;
  logic [WIDTH-1:0] grow_q, grow_d;
  logic [WIDTH-1:0] accsum_q, accsum_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] wout_q, wout_d;
  logic [WIDTH-1:0] tout_q, tout_d;
  rsp_t rsp_q;
  logic rsp_valid_q;

  logic [WIDTH-1:0] eff;
  logic [WIDTH-1:0] lim;
  logic [WIDTH-1:0] half;
  logic [WIDTH:0]   trial;
  logic             rsp_load;

  assign eff      = (req_q.window_now == '0) ? ONE : req_q.window_now;
  assign lim      = (clamp_q == '0) ? eff : clamp_q;
  assign half     = req_q.window_now >> 1;
  assign trial    = {rem_q, quo_q[WIDTH-1]} - {1'b0, eff};
  assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready);

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) state_d = ST_SUM;
      end
      ST_SUM: state_d = ST_DECIDE;
      ST_DECIDE: begin
        state_d = ST_DONE;
        if (req_q.opcode == OP_ACK && req_q.window_limited && req_q.acked_count != '0) begin
          if (eff < req_q.threshold_now) begin
            state_d = ST_CLAMP;
          end else if (accsum_q >= eff) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(WIDTH - 1)) state_d = ST_GROW;
      end
      ST_GROW: state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_DONE;
      ST_DONE: begin
        if (rsp_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    acc_d    = acc_q;
    loss_d   = loss_q;
    grow_d   = grow_q;
    accsum_d = accsum_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    wout_d   = wout_q;
    tout_d   = tout_q;
    unique case (state_q)
      ST_SUM: begin
        grow_d   = eff + WIDTH'(req_q.acked_count);
        accsum_d = acc_q + WIDTH'(req_q.acked_count);
      end
      ST_DECIDE: begin
        wout_d = req_q.window_now;
        tout_d = '0;
        unique case (req_q.opcode)
          OP_RESET: begin
            acc_d  = '0;
            loss_d = '0;
          end
          OP_ACK: begin
            if (req_q.window_limited && req_q.acked_count != '0
                && !(eff < req_q.threshold_now)) begin
              acc_d = accsum_q;
              quo_d = accsum_q;
              rem_d = '0;
              cnt_d = '0;
            end
          end
          OP_LOSS: begin
            tout_d = (half < MIN_THRESHOLD) ? MIN_THRESHOLD : half;
            acc_d  = '0;
            loss_d = loss_q + ONE;
          end
          OP_UNDO: begin
            wout_d = (req_q.prior_window > req_q.window_now) ? req_q.prior_window
                                                              : req_q.window_now;
          end
          default: wout_d = req_q.window_now;
        endcase
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (!trial[WIDTH]) begin
          rem_d = trial[WIDTH-1:0];
          quo_d = {quo_q[WIDTH-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
          quo_d = {quo_q[WIDTH-2:0], 1'b0};
        end
      end
      ST_GROW: begin
        acc_d  = rem_q;
        grow_d = req_q.window_now + quo_q;
      end
      ST_CLAMP: wout_d = (grow_q > lim) ? lim : grow_q;
      ST_IDLE, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clamp_q     <= '0;
      acc_q       <= '0;
      loss_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      loss_q  <= loss_d;
      if (cfg_we_i) clamp_q <= cfg_wdata_i;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) req_q <= req_i.data;
    grow_q   <= grow_d;
    accsum_q <= accsum_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    wout_q   <= wout_d;
    tout_q   <= tout_d;
    if (rsp_load) begin
      rsp_q.window_out    <= wout_q;
      rsp_q.threshold_out <= tout_q;
      rsp_q.loss_total    <= loss_q;
    end
  end

endmodule

FILE: rtl/core/aimd_checker.sv
// aimd_checker: port-level assertions for the aimd congestion window engine
// depends on aimd_pkg; bound to aimd_congestion_window_top below
module aimd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [aimd_pkg::WIDTH-1:0] threshold_i
);
  import aimd_pkg::*;

  // result held until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before it was taken");

  // one request in flight
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second request taken while busy");

  // no result in the cycle right after a request
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_valid_i && req_ready_i))
    else $error("result appeared too early");

  // loss threshold never below the floor
  a_thr_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && threshold_i != '0 |-> threshold_i >= MIN_THRESHOLD)
    else $error("threshold below minimum");

endmodule

bind aimd_congestion_window_top aimd_checker u_aimd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .threshold_i (rsp_o.data.threshold_out)
);

FILE: tb/tb_aimd_congestion_window_top.sv
`timescale 1ns / 1ps
// tb_aimd_congestion_window_top: self-checking bench for the aimd congestion window engine
// predicts window, threshold and loss count per request; random idling and output backpressure
// depends on aimd_pkg, aimd_req_if, aimd_rsp_if and aimd_congestion_window_top
module tb_aimd_congestion_window_top;
  import aimd_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [WIDTH-1:0] cfg_wdata_i;

  aimd_req_if req_if ();
  aimd_rsp_if rsp_if ();

  aimd_congestion_window_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  logic [WIDTH-1:0] clamp_setting = '0;
  logic [WIDTH-1:0] ack_backlog = '0;
  logic [WIDTH-1:0] loss_tally = '0;
  rsp_t             expected_updates[$];
  int unsigned      mismatches = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      rsp_hold_cycles = 0;
  bit               idling_on = 1'b1;

  logic [WIDTH-1:0] flow_wnd = 32'd10;
  logic [WIDTH-1:0] flow_thr = 32'd64;
  logic [WIDTH-1:0] flow_prior = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic rsp_t predict_window_update(input req_t ev);
    rsp_t             upd;
    logic [WIDTH-1:0] eff;
    logic [WIDTH-1:0] lim;
    logic [WIDTH-1:0] grown;
    logic [WIDTH-1:0] delta;
    upd.window_out = ev.window_now;
    upd.threshold_out = '0;
    case (ev.opcode)
      OP_RESET: begin
        ack_backlog = '0;
        loss_tally = '0;
      end
      OP_ACK: begin
        if (ev.window_limited && ev.acked_count != '0) begin
          eff = (ev.window_now == '0) ? ONE : ev.window_now;
          lim = (clamp_setting == '0) ? eff : clamp_setting;
          if (eff < ev.threshold_now) begin
            grown = eff + WIDTH'(ev.acked_count);
            upd.window_out = (grown > lim) ? lim : grown;
          end else begin
            ack_backlog = ack_backlog + WIDTH'(ev.acked_count);
            if (ack_backlog >= eff) begin
              delta = ack_backlog / eff;
              ack_backlog = ack_backlog - delta * eff;
              grown = ev.window_now + delta;
              upd.window_out = (grown > lim) ? lim : grown;
            end
          end
        end
      end
      OP_LOSS: begin
        upd.threshold_out = ev.window_now >> 1;
        if (upd.threshold_out < MIN_THRESHOLD) begin
          upd.threshold_out = MIN_THRESHOLD;
        end
        ack_backlog = '0;
        loss_tally = loss_tally + ONE;
      end
      default: begin
        upd.window_out = (ev.prior_window > ev.window_now) ? ev.prior_window : ev.window_now;
      end
    endcase
    upd.loss_total = loss_tally;
    return upd;
  endfunction

  // results are checked before the new request is predicted
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_updates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: window %h threshold %h losses %h",
                     rsp_if.data.window_out, rsp_if.data.threshold_out,
                     rsp_if.data.loss_total);
          end
        end else begin
          want = expected_updates.pop_front();
          if (rsp_if.data.window_out !== want.window_out ||
              rsp_if.data.threshold_out !== want.threshold_out ||
              rsp_if.data.loss_total !== want.loss_total) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"mismatch: window exp %h got %h, threshold exp %h got %h,",
                        " losses exp %h got %h"},
                       want.window_out, rsp_if.data.window_out,
                       want.threshold_out, rsp_if.data.threshold_out,
                       want.loss_total, rsp_if.data.loss_total);
            end
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        expected_updates.push_back(predict_window_update(req_if.data));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result sink: long hold on request, otherwise random stall bursts
  initial begin
    int unsigned n;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_hold_cycles != 0) begin
        rsp_if.ready <= 1'b0;
        n = rsp_hold_cycles;
        rsp_hold_cycles = 0;
        repeat (n) @(posedge clk_i);
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  function automatic req_t make_req(input op_e op, input logic [ACK_W-1:0] acked,
                                    input logic [WIDTH-1:0] wnd, input logic [WIDTH-1:0] thr,
                                    input logic [WIDTH-1:0] prior, input logic limited);
    req_t ev;
    ev.opcode = op;
    ev.acked_count = acked;
    ev.window_now = wnd;
    ev.threshold_now = thr;
    ev.prior_window = prior;
    ev.window_limited = limited;
    return ev;
  endfunction

  task automatic send_event(input req_t ev);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= ev;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // advance the clock first so the last accepted request is already queued
  task automatic drain_requests();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_clamp(input logic [WIDTH-1:0] value);
    drain_requests();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    clamp_setting = value;
  endtask

  function automatic logic [WIDTH-1:0] pick_window();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 60) return WIDTH'($urandom_range(1, 64));
    if (pick < 85) return WIDTH'($urandom_range(65, 5000));
    if (pick < 95) return WIDTH'($urandom());
    return 32'hFFFF_FFFF - WIDTH'($urandom_range(0, 3));
  endfunction

  function automatic logic [WIDTH-1:0] pick_threshold(input logic [WIDTH-1:0] wnd);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return wnd + WIDTH'($urandom_range(1, 200));
    if (pick < 55) return WIDTH'($urandom_range(0, 64));
    if (pick < 70) return '1;
    if (pick < 80) return '0;
    return WIDTH'($urandom());
  endfunction

  function automatic logic [ACK_W-1:0] pick_acked();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return '0;
    if (pick < 70) return ACK_W'($urandom_range(1, 8));
    if (pick < 90) return ACK_W'($urandom_range(1, 300));
    return ACK_W'($urandom());
  endfunction

  // one step of a plausible connection; window tracked roughly by the generator
  function automatic req_t flow_event();
    req_t             ev;
    int unsigned      pick;
    logic [WIDTH-1:0] eff;
    logic [WIDTH-1:0] lim;
    logic [WIDTH-1:0] grown;
    pick = $urandom_range(0, 99);
    ev = make_req(OP_ACK, pick_acked(), flow_wnd, flow_thr, flow_prior,
                  $urandom_range(0, 9) != 0);
    if (pick < 5) begin
      ev.opcode = OP_RESET;
      flow_wnd = pick_window();
      flow_thr = pick_threshold(flow_wnd);
      flow_prior = '0;
    end else if (pick < 80) begin
      if (ev.window_limited && ev.acked_count != '0) begin
        eff = (flow_wnd == '0) ? ONE : flow_wnd;
        lim = (clamp_setting == '0) ? eff : clamp_setting;
        if (eff < flow_thr) begin
          grown = eff + WIDTH'(ev.acked_count);
          flow_wnd = (grown > lim) ? lim : grown;
        end else if ($urandom_range(0, 3) == 0 && flow_wnd < lim) begin
          flow_wnd = flow_wnd + ONE;
        end
      end
    end else if (pick < 92) begin
      ev.opcode = OP_LOSS;
      flow_prior = flow_wnd;
      flow_thr = ((flow_wnd >> 1) < MIN_THRESHOLD) ? MIN_THRESHOLD : (flow_wnd >> 1);
      flow_wnd = flow_thr;
    end else begin
      ev.opcode = OP_UNDO;
      if (flow_prior > flow_wnd) flow_wnd = flow_prior;
    end
    return ev;
  endfunction

  function automatic req_t noise_event();
    return make_req(op_e'($urandom_range(0, 3)), ACK_W'($urandom()),
                    ($urandom_range(0, 1) != 0) ? pick_window() : WIDTH'($urandom()),
                    WIDTH'($urandom()), WIDTH'($urandom()), $urandom_range(0, 1) != 0);
  endfunction

  task automatic test_event_kinds();
    send_event(make_req(OP_RESET, '1, '1, '1, '1, 1'b1));
    send_event(make_req(OP_ACK, 16'd5, 32'd10, 32'd100, 32'd0, 1'b0));
    send_event(make_req(OP_ACK, 16'd0, 32'd10, 32'd100, 32'd0, 1'b1));
    send_event(make_req(OP_ACK, 16'd3, 32'd0, 32'd10, 32'd0, 1'b1));
    send_event(make_req(OP_ACK, 16'hFFFF, 32'd10, 32'd100, 32'd0, 1'b1));
    send_event(make_req(OP_ACK, 16'd30, 32'd100, 32'd50, 32'd0, 1'b1));
    send_event(make_req(OP_ACK, 16'd250, 32'd100, 32'd50, 32'd0, 1'b1));
    send_event(make_req(OP_ACK, 16'd7, 32'd0, 32'd0, 32'd0, 1'b1));
    send_event(make_req(OP_LOSS, 16'd0, 32'd0, 32'd9, 32'd0, 1'b1));
    send_event(make_req(OP_LOSS, 16'd0, 32'd3, 32'd9, 32'd0, 1'b0));
    send_event(make_req(OP_LOSS, 16'd0, 32'd6, 32'd9, 32'd0, 1'b1));
    send_event(make_req(OP_LOSS, 16'hFFFF, '1, '1, '1, 1'b1));
    send_event(make_req(OP_UNDO, 16'd0, 32'd20, 32'd9, 32'd50, 1'b1));
    send_event(make_req(OP_UNDO, 16'd0, 32'd50, 32'd9, 32'd20, 1'b1));
    send_event(make_req(OP_UNDO, 16'd0, 32'd0, 32'd0, '1, 1'b0));
    send_event(make_req(OP_RESET, '0, '0, '0, '0, 1'b0));
    drain_requests();
  endtask

  task automatic test_clamp_extremes();
    set_clamp('1);
    send_event(make_req(OP_ACK, 16'hFFFF, 32'hFFFF_FFF0, '1, 32'd0, 1'b1));
    send_event(make_req(OP_ACK, 16'd250, 32'd100, 32'd50, 32'd0, 1'b1));
    send_event(make_req(OP_ACK, 16'd20, 32'd10, 32'd100, 32'd0, 1'b1));
    set_clamp(ONE);
    send_event(make_req(OP_ACK, 16'd5, 32'd10, 32'd100, 32'd0, 1'b1));
    send_event(make_req(OP_ACK, 16'd9, 32'd4, 32'd0, 32'd0, 1'b1));
    drain_requests();
  endtask

  // sink holds off while requests keep coming, so the engine backs up
  task automatic test_output_backpressure();
    set_clamp(32'd1000);
    idling_on = 1'b0;
    rsp_hold_cycles = HOLD_CYCLES;
    repeat (10) send_event(flow_event());
    idling_on = 1'b1;
    drain_requests();
  endtask

  task automatic test_random_flows(input int unsigned count, input logic [WIDTH-1:0] clamp,
                                   input bit with_idling);
    set_clamp(clamp);
    idling_on = with_idling;
    repeat (count) begin
      send_event(($urandom_range(0, 4) == 0) ? noise_event() : flow_event());
    end
    drain_requests();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_event_kinds();
    test_clamp_extremes();
    test_output_backpressure();
    test_random_flows(400, '0, 1'b1);
    test_random_flows(400, WIDTH'($urandom_range(16, 512)), 1'b1);
    test_random_flows(300, '1, 1'b1);
    test_random_flows(250, WIDTH'($urandom()), 1'b1);
    test_random_flows(200, WIDTH'($urandom_range(64, 4096)), 1'b0);
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
